>>> rtl/ppb_pkg.sv
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared widths and codes of the page protection bitmap.
// ----------------------------------------------------------------------------
package ppb_pkg;

    // field widths
    localparam int ADDR_W     = 48;
    localparam int PAGE_NUM_W = 36;
    localparam int COUNT_W    = 17;
    localparam int OP_W       = 2;
    localparam int PERM_W     = 3;
    localparam int STATUS_W   = 2;

    // visible pages never exceed the 17-bit page count
    localparam int PAGE_W      = 17;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int WORD_IDX_W  = PAGE_W - BIT_W;
    // a chunk around a page at or above 2**DIV_W lies wholly past any count
    localparam int DIV_W       = PAGE_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_PROTECT     = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY_PAGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY_CHUNK = 2'd2;

    // permission codes
    localparam logic [PERM_W-1:0] PERM_NONE = 3'd0;
    localparam logic [PERM_W-1:0] PERM_FULL = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PERM = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

endpackage

>>> rtl/ppb_store.sv
// ----------------------------------------------------------------------------
// ppb_store
// Protection bit store: 64-bit words, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppb_store #(
    parameter longint unsigned DEPTH = 1024,
    parameter int              AW    = 10
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [ppb_pkg::WORD_BITS-1:0]   wr_data,
    input  logic [AW-1:0]                   rd_addr,
    output logic [ppb_pkg::WORD_BITS-1:0]   rd_data
);
    import ppb_pkg::*;

    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/page_protection_bitmap.sv
// ----------------------------------------------------------------------------
// page_protection_bitmap
// One protection bit per guest page; protect ranges, query pages and chunks.
// ----------------------------------------------------------------------------
// Flow: protect rewrites each store word touched; page query tests one
//   word; chunk query takes a reciprocal remainder, then tests each word.
// Throughput: one item at a time, set by the store walked one word per
//   read-modify step; s_ready is low until the result is taken.
// Reset: synchronous, active low; a clearing pass then zeroes the store,
//   one word a cycle, all (MAX_PAGES + 63) / 64 words (1024 by default).
// ----------------------------------------------------------------------------
module page_protection_bitmap #(
    parameter longint unsigned MAX_PAGES   = 65536,
    parameter int              CHUNK_PAGES = 512,
    parameter int              PAGE_SHIFT  = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [ppb_pkg::COUNT_W-1:0]       cfg_wr_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppb_pkg::OP_W-1:0]          s_operation,
    input  logic [ppb_pkg::ADDR_W-1:0]        s_start_address,
    input  logic [ppb_pkg::ADDR_W-1:0]        s_range_length,
    input  logic [ppb_pkg::PERM_W-1:0]        s_permission,
    input  logic [ppb_pkg::PAGE_NUM_W-1:0]    s_page_number,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppb_pkg::STATUS_W-1:0]      m_status,
    output logic                              m_is_protected,
    output logic [ppb_pkg::PAGE_NUM_W-1:0]    m_fault_page,
    output logic                              m_invalidate_request,
    output logic [ppb_pkg::PAGE_NUM_W-1:0]    m_invalidate_first_page,
    output logic [ppb_pkg::COUNT_W-1:0]       m_invalidate_page_count
);
    import ppb_pkg::*;

    localparam longint unsigned STORE_WORDS = (MAX_PAGES + 63) / 64;
    localparam int WORD_AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int REM_W   = $clog2(CHUNK_PAGES) + 1;
    localparam int SUM_W   = ADDR_W + 1;
    localparam int LAST_W  = SUM_W - PAGE_SHIFT;
    localparam logic [PAGE_W-1:0] MAX_VIS =
        (MAX_PAGES > (2 ** PAGE_W - 1)) ? {PAGE_W{1'b1}} : PAGE_W'(MAX_PAGES);
    localparam logic [WORD_AW-1:0] LAST_STORE_WORD = WORD_AW'(STORE_WORDS - 1);
    // floor(2**DIV_W / CHUNK_PAGES); the quotient estimate is exact or one low
    localparam logic [DIV_W:0] CHUNK_RECIP =
        (DIV_W + 1)'((longint'(1) << DIV_W) / CHUNK_PAGES);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_DIVIDE,
        ST_REM,
        ST_BASE,
        ST_LIMIT,
        ST_READ,
        ST_MODIFY,
        ST_FIND,
        ST_DONE
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [WORD_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0]     tracked_reg, tracked_next;

    // result registers
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   prot_reg, prot_next;
    logic [PAGE_NUM_W-1:0]  fault_reg, fault_next;
    logic                   inv_reg, inv_next;
    logic [PAGE_NUM_W-1:0]  inv_first_reg, inv_first_next;
    logic [COUNT_W-1:0]     inv_count_reg, inv_count_next;

    // working registers
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [ADDR_W-1:0]      len_reg, len_next;
    logic [PERM_W-1:0]      perm_reg, perm_next;
    logic [PAGE_NUM_W-1:0]  page_reg, page_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [PAGE_W-1:0]      first_reg, first_next;
    logic [PAGE_W-1:0]      last_reg, last_next;
    logic [WORD_IDX_W-1:0]  word_reg, word_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       quot_reg, quot_next;
    logic [WORD_BITS-1:0]   hit_reg, hit_next;

    // datapath signals
    logic [PAGE_W-1:0]      visible;
    logic [LAST_W-1:0]      last_pg;
    logic [PAGE_NUM_W-1:0]  base;
    logic [PAGE_W:0]        chunk_end;
    logic [PAGE_W-1:0]      chunk_lim;
    logic [2*DIV_W-1:0]     quot_prod;
    logic [DIV_W-1:0]       quot_est;
    logic [DIV_W-1:0]       rem_est;
    logic [BIT_W-1:0]       mask_lo, mask_hi;
    logic [WORD_BITS-1:0]   mask;
    logic [WORD_BITS-1:0]   lowbit;
    logic [BIT_W-1:0]       hit_idx;
    logic                   at_last_word;

    // store port
    logic                   st_wr_en;
    logic [WORD_AW-1:0]     st_wr_addr;
    logic [WORD_BITS-1:0]   st_wr_data;
    logic [WORD_BITS-1:0]   st_rd_data;

    ppb_store #(
        .DEPTH (STORE_WORDS),
        .AW    (WORD_AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (WORD_AW'(word_reg)),
        .rd_data (st_rd_data)
    );

    // pages beyond the store never count
    assign visible = (PAGE_W'(tracked_reg) > MAX_VIS) ? MAX_VIS : PAGE_W'(tracked_reg);

    // range end page and chunk base
    assign last_pg   = LAST_W'(sum_reg >> PAGE_SHIFT);
    assign base      = page_reg - PAGE_NUM_W'(rem_reg);
    assign chunk_end = {1'b0, first_reg} + (PAGE_W + 1)'(CHUNK_PAGES);
    assign chunk_lim = (chunk_end > {1'b0, visible}) ? visible : chunk_end[PAGE_W-1:0];

    // page % CHUNK_PAGES by reciprocal multiply, then one correcting subtract
    assign quot_prod = (2*DIV_W)'(page_reg[DIV_W-1:0]) * (2*DIV_W)'(CHUNK_RECIP);
    assign quot_est  = quot_prod[2*DIV_W-1:DIV_W];
    assign rem_est   = page_reg[DIV_W-1:0] - DIV_W'(quot_reg * DIV_W'(CHUNK_PAGES));

    // bit mask of the pages of the current word inside [first, last]
    assign at_last_word = (word_reg == last_reg[PAGE_W-1:BIT_W]);
    assign mask_lo = (word_reg == first_reg[PAGE_W-1:BIT_W]) ? first_reg[BIT_W-1:0] : '0;
    assign mask_hi = at_last_word ? last_reg[BIT_W-1:0] : {BIT_W{1'b1}};
    assign mask    = ({WORD_BITS{1'b1}} << mask_lo)
                   & ({WORD_BITS{1'b1}} >> ({BIT_W{1'b1}} - mask_hi));

    // position of the lowest set bit of the hit word
    assign lowbit = hit_reg & (~hit_reg + WORD_BITS'(1));
    always_comb begin
        hit_idx = '0;
        for (int b = 0; b < BIT_W; b++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    hit_idx[b] = hit_idx[b] | lowbit[i];
                end
            end
        end
    end

    // store write: clearing pass or read-modify-write of a range
    always_comb begin
        st_wr_en   = 1'b0;
        st_wr_addr = WORD_AW'(word_reg);
        st_wr_data = (perm_reg == PERM_NONE) ? (st_rd_data | mask) : (st_rd_data & ~mask);
        if (state_reg == ST_CLEAR) begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_addr_reg;
            st_wr_data = '0;
        end else if (state_reg == ST_MODIFY && op_reg == OP_PROTECT) begin
            st_wr_en = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        tracked_next   = tracked_reg;
        status_next    = status_reg;
        prot_next      = prot_reg;
        fault_next     = fault_reg;
        inv_next       = inv_reg;
        inv_first_next = inv_first_reg;
        inv_count_next = inv_count_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        perm_next      = perm_reg;
        page_next      = page_reg;
        sum_next       = sum_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        word_next      = word_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        hit_next       = hit_reg;

        if (cfg_wr_en) begin
            tracked_next = cfg_wr_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == LAST_STORE_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_operation;
                    addr_next      = s_start_address;
                    len_next       = s_range_length;
                    perm_next      = s_permission;
                    page_next      = s_page_number;
                    status_next    = STATUS_OK;
                    prot_next      = 1'b0;
                    fault_next     = '0;
                    inv_next       = 1'b0;
                    inv_first_next = '0;
                    inv_count_next = '0;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                case (op_reg)
                    OP_PROTECT: begin
                        sum_next = SUM_W'(addr_reg) + SUM_W'(len_reg) - SUM_W'(1);
                        if (len_reg == '0) begin
                            status_next = STATUS_ZERO_LEN;
                            state_next  = ST_DONE;
                        end else if (perm_reg != PERM_NONE && perm_reg != PERM_FULL) begin
                            status_next = STATUS_BAD_PERM;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_RANGE;
                        end
                    end
                    OP_QUERY_PAGE: begin
                        first_next = page_reg[PAGE_W-1:0];
                        last_next  = page_reg[PAGE_W-1:0];
                        word_next  = page_reg[PAGE_W-1:BIT_W];
                        if (page_reg[PAGE_NUM_W-1:PAGE_W] != '0
                                || page_reg[PAGE_W-1:0] >= visible) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    OP_QUERY_CHUNK: begin
                        // far pages have a chunk past every tracked page
                        if (page_reg[PAGE_NUM_W-1:DIV_W] != '0) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_DIVIDE;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RANGE: begin
                first_next = PAGE_W'(addr_reg >> PAGE_SHIFT);
                last_next  = last_pg[PAGE_W-1:0];
                word_next  = WORD_IDX_W'(addr_reg >> (PAGE_SHIFT + BIT_W));
                if (last_pg >= LAST_W'(visible)) begin
                    status_next = STATUS_RANGE;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DIVIDE: begin
                quot_next  = quot_est;
                state_next = ST_REM;
            end
            ST_REM: begin
                if (rem_est >= DIV_W'(CHUNK_PAGES)) begin
                    rem_next = REM_W'(rem_est - DIV_W'(CHUNK_PAGES));
                end else begin
                    rem_next = REM_W'(rem_est);
                end
                state_next = ST_BASE;
            end
            ST_BASE: begin
                first_next = base[PAGE_W-1:0];
                if (base[PAGE_NUM_W-1:PAGE_W] != '0 || base[PAGE_W-1:0] >= visible) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                last_next  = chunk_lim - PAGE_W'(1);
                word_next  = first_reg[PAGE_W-1:BIT_W];
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (op_reg == OP_PROTECT) begin
                    if (at_last_word) begin
                        if (perm_reg == PERM_NONE) begin
                            inv_next       = 1'b1;
                            inv_first_next = PAGE_NUM_W'(first_reg);
                            inv_count_next = COUNT_W'(last_reg - first_reg + PAGE_W'(1));
                        end
                        state_next = ST_DONE;
                    end else begin
                        word_next  = word_reg + WORD_IDX_W'(1);
                        state_next = ST_READ;
                    end
                end else begin
                    hit_next   = st_rd_data & mask;
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                if (hit_reg != '0) begin
                    prot_next = 1'b1;
                    if (op_reg == OP_QUERY_CHUNK) begin
                        fault_next = PAGE_NUM_W'({word_reg, hit_idx});
                    end
                    state_next = ST_DONE;
                end else if (at_last_word) begin
                    state_next = ST_DONE;
                end else begin
                    word_next  = word_reg + WORD_IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            tracked_reg   <= '0;
            status_reg    <= STATUS_OK;
            prot_reg      <= 1'b0;
            fault_reg     <= '0;
            inv_reg       <= 1'b0;
            inv_first_reg <= '0;
            inv_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            tracked_reg   <= tracked_next;
            status_reg    <= status_next;
            prot_reg      <= prot_next;
            fault_reg     <= fault_next;
            inv_reg       <= inv_next;
            inv_first_reg <= inv_first_next;
            inv_count_reg <= inv_count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        len_reg     <= len_next;
        perm_reg    <= perm_next;
        page_reg    <= page_next;
        sum_reg     <= sum_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        word_reg    <= word_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        hit_reg     <= hit_next;
    end

    // handshake and result ports
    assign s_ready                 = (state_reg == ST_IDLE);
    assign m_valid                 = (state_reg == ST_DONE);
    assign m_status                = status_reg;
    assign m_is_protected          = prot_reg;
    assign m_fault_page            = fault_reg;
    assign m_invalidate_request    = inv_reg;
    assign m_invalidate_first_page = inv_first_reg;
    assign m_invalidate_page_count = inv_count_reg;

endmodule
